/* src/twt_pkg.sv */
// ----------------------------------------------------------------------------
// twt_pkg
// shared types and constants of the timed event wait table
// ----------------------------------------------------------------------------
package twt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int WCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 48;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // operation codes
  localparam logic [1:0] OP_WAIT  = 2'd0;
  localparam logic [1:0] OP_RAISE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // wakeup reasons
  localparam logic [1:0] REASON_EVENT   = 2'd0;
  localparam logic [1:0] REASON_TIMEOUT = 2'd1;
  localparam logic [1:0] REASON_FULL    = 2'd2;

  // no deadline held
  localparam logic [TIME_W:0] DEADLINE_NONE = {(TIME_W + 1){1'b1}};

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        task_id;
    logic              has_emitter;
    logic [7:0]        emitter_id;
    logic signed [31:0] timeout;
    logic [7:0]        error_code;
    logic [TIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [7:0] woken_task;
    logic [1:0] reason;
    logic [7:0] wake_error;
    logic       last;
  } out_item_t;

  // decoded command handed from the front to the back
  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        task_id;
    logic              listens;
    logic [7:0]        emitter;
    logic [7:0]        error;
    logic              no_deadline;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

/* src/twt_front.sv */
// ----------------------------------------------------------------------------
// twt_front
// accepts transactions and decodes them into queue commands
// ----------------------------------------------------------------------------
module twt_front
  import twt_pkg::*;
(
  input  logic      start,
  input  in_item_t  in_item,
  input  q_status_t q_status,
  output logic      busy,
  output logic      push,
  output cmd_t      push_cmd
);

  logic [TIME_W:0] sum;

  // now plus timeout, saturating at the top of the time range
  assign sum  = {1'b0, in_item.now} + {18'b0, in_item.timeout[30:0]};
  assign busy = q_status.full;
  assign push = start && !q_status.full;

  always_comb begin
    push_cmd.op          = in_item.operation;
    push_cmd.task_id     = in_item.task_id;
    push_cmd.listens     = in_item.has_emitter;
    push_cmd.emitter     = in_item.emitter_id;
    push_cmd.error       = in_item.error_code;
    push_cmd.no_deadline = in_item.timeout[31];
    push_cmd.deadline    = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    push_cmd.now         = in_item.now;
  end

endmodule

/* src/twt_queue.sv */
// ----------------------------------------------------------------------------
// twt_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module twt_queue
  import twt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output q_status_t q_status,
  output cmd_t      head
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign q_status.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_status.not_empty = (count_r != '0);
  assign head               = entry_r[rd_ptr_r];
  assign do_pop             = pop && q_status.not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/twt_back.sv */
// ----------------------------------------------------------------------------
// twt_back
// slot table, wait insertion and one-slot-per-cycle wakeup scan
// ----------------------------------------------------------------------------
module twt_back
  import twt_pkg::*;
#(
  parameter int WAIT_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(WAIT_SLOTS);
  localparam int CNT_W = $clog2(WAIT_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } back_state_t;

  typedef struct packed {
    logic [7:0]        task_id;
    logic              listens;
    logic [7:0]        emitter;
    logic              no_deadline;
    logic [TIME_W-1:0] deadline;
  } slot_t;

  slot_t mem_r [WAIT_SLOTS];
  slot_t rd_data_r;
  slot_t wr_slot;

  back_state_t           state_r, state_nxt;
  logic [WAIT_SLOTS-1:0] valid_r, valid_nxt;
  logic [TIME_W:0]       earliest_r, earliest_nxt;
  logic [TIME_W:0]       later_r, later_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [CNT_W-1:0]      issue_cnt_r, issue_cnt_nxt;
  logic                  ev_act_r, ev_act_nxt;
  logic [IDX_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic [WCNT_W-1:0]     wake_cnt_r, wake_cnt_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [7:0]            pend_task_r, pend_task_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic             mem_we;
  logic             rd_en;
  logic [IDX_W-1:0] free_idx;
  logic             table_full;
  logic             hit;
  logic             timed;
  logic [1:0]       pend_reason;
  logic [7:0]       pend_error;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign table_full = &valid_r;
  assign pop        = (state_r == ST_IDLE) && q_status.not_empty;
  assign rd_en      = (state_r == ST_SCAN) && (issue_cnt_r != CNT_W'(WAIT_SLOTS));

  assign pend_reason = (cmd_r.op == OP_RAISE) ? REASON_EVENT : REASON_TIMEOUT;
  assign pend_error  = (cmd_r.op == OP_RAISE) ? cmd_r.error : 8'd0;

  always_comb begin
    wr_slot.task_id     = head.task_id;
    wr_slot.listens     = head.listens;
    wr_slot.emitter     = head.emitter;
    wr_slot.no_deadline = head.no_deadline;
    wr_slot.deadline    = head.deadline;
  end

  // slot evaluation in the cycle after its read
  always_comb begin
    timed = valid_r[ev_idx_r] && !rd_data_r.no_deadline;
    if (cmd_r.op == OP_RAISE) begin
      hit = ev_act_r && valid_r[ev_idx_r] && rd_data_r.listens &&
            (rd_data_r.emitter == cmd_r.emitter) &&
            (wake_cnt_r < WCNT_W'(MAX_RESULTS));
    end else begin
      hit = ev_act_r && timed && (cmd_r.now >= rd_data_r.deadline) &&
            (wake_cnt_r < WCNT_W'(MAX_RESULTS));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    earliest_nxt   = earliest_r;
    later_nxt      = later_r;
    cmd_nxt        = cmd_r;
    issue_cnt_nxt  = issue_cnt_r;
    ev_act_nxt     = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    wake_cnt_nxt   = wake_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_task_nxt  = pend_task_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;

    if (hit) begin
      valid_nxt[ev_idx_r] = 1'b0;
      wake_cnt_nxt        = wake_cnt_r + 1'b1;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{woken_task: pend_task_r, reason: pend_reason,
                          wake_error: pend_error, last: 1'b0};
      end
      pend_valid_nxt = 1'b1;
      pend_task_nxt  = rd_data_r.task_id;
    end else if (ev_act_r && cmd_r.op == OP_TICK && timed &&
                 ({1'b0, rd_data_r.deadline} < later_r)) begin
      later_nxt = {1'b0, rd_data_r.deadline};
    end

    case (state_r)
      ST_IDLE: begin
        if (q_status.not_empty) begin
          cmd_nxt        = head;
          issue_cnt_nxt  = '0;
          wake_cnt_nxt   = '0;
          pend_valid_nxt = 1'b0;
          later_nxt      = DEADLINE_NONE;
          case (head.op)
            OP_WAIT: begin
              if (table_full) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{woken_task: head.task_id, reason: REASON_FULL,
                                  wake_error: 8'd0, last: 1'b1};
              end else begin
                mem_we              = 1'b1;
                valid_nxt[free_idx] = 1'b1;
                if (!head.no_deadline && ({1'b0, head.deadline} < earliest_r)) begin
                  earliest_nxt = {1'b0, head.deadline};
                end
              end
            end
            OP_RAISE: begin
              state_nxt = ST_SCAN;
            end
            OP_TICK: begin
              if ({1'b0, head.now} >= earliest_r) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          ev_act_nxt    = 1'b1;
          ev_idx_nxt    = issue_cnt_r[IDX_W-1:0];
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{woken_task: pend_task_r, reason: pend_reason,
                            wake_error: pend_error, last: 1'b1};
        end
        pend_valid_nxt = 1'b0;
        if (cmd_r.op == OP_TICK) begin
          earliest_nxt = later_r;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      earliest_r   <= DEADLINE_NONE;
      ev_act_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      issue_cnt_r  <= '0;
      wake_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      earliest_r   <= earliest_nxt;
      ev_act_r     <= ev_act_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      wake_cnt_r   <= wake_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    later_r     <= later_nxt;
    cmd_r       <= cmd_nxt;
    ev_idx_r    <= ev_idx_nxt;
    pend_task_r <= pend_task_nxt;
    out_item_r  <= out_item_nxt;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[free_idx] <= wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[issue_cnt_r[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* src/timed_event_wait_table_core.sv */
// ----------------------------------------------------------------------------
// timed_event_wait_table_core
// table of waiting tasks woken by emitter raises or by expired deadlines
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. A wait stores the task in the
// lowest free slot when it reaches the head of the queue and the back end is
// idle, and gives no result, unless the table is full, in which case one
// refusal result with last set is registered out instead. A raise, or a tick
// at or past the earliest held deadline, scans the slot memory one slot per
// cycle through its single registered read port, then a flush state emits
// any held final result; a tick before the earliest deadline, and an unknown
// operation, give nothing. Results appear on out_item for exactly one cycle,
// marked by out_valid, at most one per cycle and in slot order; the receiver
// cannot stall them, so it must take every strobe. The final result of a
// transaction carries last. After reset the table is empty and usable at
// once.
// ----------------------------------------------------------------------------
module timed_event_wait_table_core
  import twt_pkg::*;
#(
  parameter int WAIT_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;

  // front: accept and decode, deadline = now + timeout saturated
  twt_front u_front (
    .start    (start),
    .in_item  (in_item),
    .q_status (q_status),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // queue decouples acceptance from scanning
  twt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  // back: slot table, earliest deadline and the wakeup scan
  twt_back #(
    .WAIT_SLOTS (WAIT_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* src/twt_checker.sv */
// ----------------------------------------------------------------------------
// twt_checker
// port-level checks on the wait table results
// ----------------------------------------------------------------------------
module twt_checker
  import twt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // a refused wait is always a single result
  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.reason == REASON_FULL) |-> out_item.last)
    else $error("refusal result without last");

  a_reason_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.reason == REASON_EVENT) ||
                  (out_item.reason == REASON_TIMEOUT) ||
                  (out_item.reason == REASON_FULL))
    else $error("unknown wakeup reason");

  a_error_only_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.reason != REASON_EVENT) |-> (out_item.wake_error == 8'd0))
    else $error("error code on a non-event result");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !busy && !out_valid)
    else $error("activity right after reset");

endmodule

bind timed_event_wait_table_core twt_checker u_twt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for timed_event_wait_table_core
// ----------------------------------------------------------------------------
// A directed opening walks the table through its corner cases: an ignored
// opcode, zero and maximum timeouts, deadline saturation, a waiter that never
// leaves, ticks before and at the earliest deadline, raises with and without
// listeners, and a full table. Random traffic follows, mostly short sessions
// of waits then ticks and raises on a small emitter pool, with fill bursts,
// noise and time jumps mixed in. A clocked predictor works out the wakeups
// of each accepted transaction and a monitor checks every result strobe
// against them in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twt_pkg::*;

  localparam int N_SLOTS = 16;
  localparam int N_RANDOM = 400;
  localparam int DRAIN_CYCLES = 4 * (N_SLOTS + 3);
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  timed_event_wait_table_core #(
    .WAIT_SLOTS(N_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predicted table contents, only read while the valid bit is set
  logic              waiter_valid    [N_SLOTS] = '{default: 1'b0};
  logic [7:0]        waiter_task     [N_SLOTS];
  logic              waiter_listens  [N_SLOTS];
  logic [7:0]        waiter_emitter  [N_SLOTS];
  logic              waiter_open     [N_SLOTS];
  logic [TIME_W-1:0] waiter_deadline [N_SLOTS];
  logic [TIME_W:0]   next_due = DEADLINE_NONE;

  in_item_t  pending_items [$];
  out_item_t wakeups_due [$];

  int n_posted = 0;     // everything queued for the driver
  int n_counted = 0;    // same, without the ignored opcode
  int n_taken = 0;
  int n_errors = 0;
  int op_count [4] = '{default: 0};
  int reason_count [4] = '{default: 0};
  int forever_left = 2; // budget of random waiters with no way out
  int gap_left = 0;
  int burst_left = 0;
  logic in_taken = 1'b0;

  function automatic out_item_t wakeup(logic [7:0] tid, logic [1:0] why, logic [7:0] err);
    out_item_t w;
    w.woken_task = tid;
    w.reason     = why;
    w.wake_error = err;
    w.last       = 1'b0;
    return w;
  endfunction

  // next-state and wakeup list of one accepted transaction
  task automatic predict_wakeups(input in_item_t it);
    int              slot;
    int              woke;
    logic [TIME_W:0] sum;
    logic [TIME_W:0] later;
    out_item_t       held;
    logic            have_held;
    slot = -1;
    woke = 0;
    have_held = 1'b0;
    held = '0;
    case (it.operation)
      OP_WAIT: begin
        // lowest free slot wins
        for (int i = N_SLOTS - 1; i >= 0; i--)
          if (!waiter_valid[i]) slot = i;
        if (slot < 0) begin
          held = wakeup(it.task_id, REASON_FULL, 8'd0);
          have_held = 1'b1;
        end else begin
          waiter_valid[slot]   = 1'b1;
          waiter_task[slot]    = it.task_id;
          waiter_listens[slot] = it.has_emitter;
          waiter_emitter[slot] = it.emitter_id;
          waiter_open[slot]    = it.timeout[31];
          if (!it.timeout[31]) begin
            // deadline saturates at the top of the time range
            sum = {1'b0, it.now} + {17'd0, it.timeout};
            if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
            waiter_deadline[slot] = sum[TIME_W-1:0];
            if (sum < next_due) next_due = sum;
          end
        end
      end
      OP_RAISE: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (waiter_valid[i] && waiter_listens[i] && waiter_emitter[i] == it.emitter_id &&
              woke < MAX_RESULTS) begin
            waiter_valid[i] = 1'b0;
            if (have_held) wakeups_due.push_back(held);
            held = wakeup(waiter_task[i], REASON_EVENT, it.error_code);
            have_held = 1'b1;
            woke++;
          end
        end
      end
      OP_TICK: begin
        // no scan while time is short of the earliest held deadline
        if ({1'b0, it.now} >= next_due) begin
          later = DEADLINE_NONE;
          for (int i = 0; i < N_SLOTS; i++) begin
            if (waiter_valid[i] && !waiter_open[i]) begin
              if (it.now >= waiter_deadline[i] && woke < MAX_RESULTS) begin
                waiter_valid[i] = 1'b0;
                if (have_held) wakeups_due.push_back(held);
                held = wakeup(waiter_task[i], REASON_TIMEOUT, 8'd0);
                have_held = 1'b1;
                woke++;
              end else if ({1'b0, waiter_deadline[i]} < later) begin
                later = {1'b0, waiter_deadline[i]};
              end
            end
          end
          next_due = later;
        end
      end
      default: ;
    endcase
    if (have_held) begin
      held.last = 1'b1;
      wakeups_due.push_back(held);
    end
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic signed [31:0] any_timeout();
    if ($urandom_range(0, 3) == 0) return -1;
    return $urandom_range(0, 32'h7FFF_FFFF);
  endfunction

  // mostly a small pool so raises find listeners
  function automatic logic [7:0] pick_emitter();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 3));
    return any_byte();
  endfunction

  // mostly short timeouts; waiters with no deadline need an emitter, bar a few
  function automatic logic signed [31:0] wait_timeout(input logic has_em);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15 && (has_em || forever_left > 0)) begin
      if (!has_em) forever_left--;
      return -1;
    end
    if (r < 75) return $urandom_range(0, 40);
    if (r < 90) return $urandom_range(0, 2000);
    return $urandom_range(0, 32'h7FFF_FFFF);
  endfunction

  task automatic post_item(input logic [1:0] op, input logic [7:0] tid, input logic has_em,
                           input logic [7:0] em, input logic signed [31:0] tmo,
                           input logic [7:0] err, input logic [TIME_W-1:0] at);
    in_item_t it;
    it.operation   = op;
    it.task_id     = tid;
    it.has_emitter = has_em;
    it.emitter_id  = em;
    it.timeout     = tmo;
    it.error_code  = err;
    it.now         = at;
    pending_items.push_back(it);
    n_posted++;
    if (op != OP_UNKNOWN) n_counted++;
  endtask

  // unused fields of each opcode carry random values
  task automatic post_wait(input logic [7:0] tid, input logic has_em, input logic [7:0] em,
                           input logic signed [31:0] tmo, input logic [TIME_W-1:0] at);
    post_item(OP_WAIT, tid, has_em, em, tmo, any_byte(), at);
  endtask

  task automatic post_raise(input logic [7:0] em, input logic [7:0] err);
    post_item(OP_RAISE, any_byte(), 1'($urandom_range(0, 1)), em, any_timeout(), err,
              any_time());
  endtask

  task automatic post_tick(input logic [TIME_W-1:0] at);
    post_item(OP_TICK, any_byte(), 1'($urandom_range(0, 1)), any_byte(), any_timeout(),
              any_byte(), at);
  endtask

  // idle gap before each transaction, with runs of back-to-back traffic
  function automatic int pick_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // ---------------------------------------------------------------- driver

  // drives at the falling edge; a transaction holds until start && !busy is seen
  always @(negedge clk) begin
    logic drive_next;
    if (rst_n) begin
      drive_next = start && !in_taken;
      if (start && in_taken) gap_left = pick_gap();
      if (!drive_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          drive_next = 1'b1;
        end
      end
      start <= drive_next;
    end
  end

  // ---------------------------------------------------------------- monitor

  // acceptances are predicted before result checks, so same-edge order is safe
  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= start && !busy;
      if (start && !busy) begin
        predict_wakeups(in_item);
        n_taken++;
        op_count[in_item.operation]++;
      end
      if (out_valid) begin
        if (wakeups_due.size() == 0) begin
          $error("wakeup with none pending: task %0d reason %0d", out_item.woken_task,
                 out_item.reason);
          n_errors++;
        end else begin
          due = wakeups_due.pop_front();
          check_field("woken_task", due.woken_task, out_item.woken_task);
          check_field("reason", 8'(due.reason), 8'(out_item.reason));
          check_field("wake_error", due.wake_error, out_item.wake_error);
          check_field("last", 8'(due.last), 8'(out_item.last));
          reason_count[due.reason]++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [TIME_W-1:0] gen_now;
    logic              has;
    int                r;
    int                base;

    // ignored opcode with every field at its top value
    post_item(OP_UNKNOWN, 8'hFF, 1'b1, 8'hFF, -1, 8'hFF, TIME_MAX);
    // listener with no deadline
    post_wait(8'h00, 1'b1, 8'h00, -1, '0);
    // zero timeout, due at now
    post_wait(8'hFF, 1'b1, 8'hFF, 0, 48'd100);
    // largest timeout
    post_wait(8'h5A, 1'b0, 8'hA5, 32'sh7FFF_FFFF, 48'd100);
    // neither emitter nor deadline, holds its slot for good
    post_wait(8'h33, 1'b0, 8'h00, -1, 48'd100);
    // deadline past the time range saturates
    post_wait(8'h44, 1'b0, 8'h0F, 7, TIME_MAX - 48'd3);
    // one short of the earliest deadline, then right on it
    post_tick(48'd99);
    post_tick(48'd100);
    // raise with nobody listening, then one that wakes the first waiter
    post_raise(8'hFF, 8'hFF);
    post_raise(8'h00, 8'h81);
    // fill the table, every second waiter listening on one emitter
    for (int k = 0; k < 13; k++)
      post_wait(8'h10 + 8'(k), 1'(k), 8'h3C, k + 1, 48'd200);
    post_wait(8'hC3, 1'b1, 8'h3C, 5, 48'd200);
    post_raise(8'h3C, 8'h42);
    // everything with a deadline goes at the end of time
    post_tick(TIME_MAX);

    // random part
    base = n_counted;
    gen_now = 48'd1000;
    while (n_counted - base < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        // session: a few waits, then ticks and raises that wake them
        repeat ($urandom_range(1, 6)) begin
          gen_now += $urandom_range(0, 5);
          has = ($urandom_range(0, 9) < 7);
          post_wait(any_byte(), has, pick_emitter(), wait_timeout(has), gen_now);
        end
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) != 0) begin
            gen_now += $urandom_range(0, 30);
            post_tick(gen_now);
          end else begin
            post_raise(pick_emitter(), any_byte());
          end
        end
      end else if (r < 68) begin
        gen_now += $urandom_range(0, 60);
        post_tick(gen_now);
      end else if (r < 82) begin
        post_raise(pick_emitter(), any_byte());
      end else if (r < 90) begin
        // fill burst, runs into refusals
        repeat ($urandom_range(8, 17)) begin
          has = ($urandom_range(0, 9) < 9);
          post_wait(any_byte(), has, pick_emitter(), wait_timeout(has), gen_now);
        end
        post_raise(pick_emitter(), any_byte());
        post_raise(pick_emitter(), any_byte());
        gen_now += 50;
        post_tick(gen_now);
      end else if (r < 96) begin
        // noise: unknown opcode, tick back in time, raise on a stray emitter
        case ($urandom_range(0, 2))
          0: post_item(OP_UNKNOWN, any_byte(), 1'($urandom_range(0, 1)), any_byte(),
                       any_timeout(), any_byte(), any_time());
          1: post_tick(gen_now - $urandom_range(1, 40));
          default: post_raise(any_byte(), any_byte());
        endcase
      end else begin
        // time jump, sometimes to the edge of the range
        if ($urandom_range(0, 3) == 0) gen_now = TIME_MAX - $urandom_range(0, 40);
        else gen_now = any_time();
        post_tick(gen_now);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all transactions in, all wakeups out, then a quiet tail for strays
    while (n_taken < n_posted) @(negedge clk);
    while (wakeups_due.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d transactions: %0d wait, %0d raise, %0d tick, %0d unknown opcode",
             n_taken, op_count[OP_WAIT], op_count[OP_RAISE], op_count[OP_TICK],
             op_count[OP_UNKNOWN]);
    $display("wakeups checked: %0d by event, %0d timed out, %0d refused",
             reason_count[REASON_EVENT], reason_count[REASON_TIMEOUT],
             reason_count[REASON_FULL]);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("watchdog expired, %0d of %0d transactions taken, %0d wakeups pending",
             n_taken, n_posted, wakeups_due.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
